[sv/scti_pkg.sv]
// Shared types, constants and helpers for the sorted crossing table localizer.
package scti_pkg;

  localparam int MAX_POINTS = 64;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int IDX_W      = 7;
  localparam int PAR_W      = 32;
  localparam int TOL_W      = 31;
  localparam int ORI_W      = 2;
  localparam int ENT_W      = PAR_W + ORI_W;

  typedef enum logic [2:0] {
    ACT_START = 3'd0,
    ACT_INS   = 3'd1,
    ACT_AVAL  = 3'd2,
    ACT_BVAL  = 3'd3,
    ACT_AIDX  = 3'd4,
    ACT_BIDX  = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NREADY = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  localparam logic [ORI_W-1:0] OR_FWD = 2'd0;
  localparam logic [ORI_W-1:0] OR_REV = 2'd1;
  localparam logic [ORI_W-1:0] OR_EXT = 2'd2;

  localparam logic [1:0] TR_IN  = 2'd0;
  localparam logic [1:0] TR_OUT = 2'd1;

  localparam logic [1:0] FACE_FWD = 2'd0;
  localparam logic [1:0] FACE_REV = 2'd1;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [PAR_W-1:0] value;
    logic [1:0]              transition;
    logic [1:0]              face_side;
    logic [IDX_W-1:0]        start_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [ORI_W-1:0] orientation;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] last_index;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [AW-1:0]    waddr;
    logic [ENT_W-1:0] wdata;
    logic [AW-1:0]    raddr;
  } mem_req_t;

  typedef struct packed {
    logic signed [PAR_W-1:0] a;
    logic signed [PAR_W-1:0] b;
    logic                    use_tol;
  } cmp_req_t;

  function automatic logic [ORI_W-1:0] orient_of(input logic [1:0] tr,
                                                 input logic [1:0] face);
    logic [ORI_W-1:0] o;
    o = OR_EXT;
    if (tr == TR_IN) begin
      if (face == FACE_FWD) o = OR_FWD;
      else if (face == FACE_REV) o = OR_REV;
    end else if (tr == TR_OUT) begin
      if (face == FACE_FWD) o = OR_REV;
      else if (face == FACE_REV) o = OR_FWD;
    end
    return o;
  endfunction

endpackage

[sv/scti_in_if.sv]
// Input channel: valid/ready handshake with the action payload.
interface scti_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [2:0]                             action;
  logic signed [scti_pkg::PAR_W-1:0]      value;
  logic [1:0]                             transition;
  logic [1:0]                             face_side;
  logic [scti_pkg::IDX_W-1:0]             start_index;

  modport source (output valid, action, value, transition, face_side, start_index,
                  input ready);
  modport sink   (input valid, action, value, transition, face_side, start_index,
                  output ready);
endinterface

[sv/scti_out_if.sv]
// Result channel: valid/ready handshake with the query/insert result payload.
interface scti_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic                             found;
  logic [scti_pkg::ORI_W-1:0]       orientation;
  logic [scti_pkg::IDX_W-1:0]       first_index;
  logic [scti_pkg::IDX_W-1:0]       last_index;
  logic [scti_pkg::IDX_W-1:0]       point_count;

  modport source (output valid, status, found, orientation, first_index, last_index,
                  point_count, input ready);
  modport sink   (input valid, status, found, orientation, first_index, last_index,
                  point_count, output ready);
endinterface

[sv/scti_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module scti_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 34
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/scti_cmp.sv]
// Shared compare unit: flags (a - b) > tol, or (a - b) > 0 without tolerance.
module scti_cmp (
  input  scti_pkg::cmp_req_t               req,
  input  logic [scti_pkg::TOL_W-1:0]       tol,
  output logic                             gt
);

  localparam int DW = scti_pkg::PAR_W + 2;

  logic signed [DW-1:0] a_x;
  logic signed [DW-1:0] b_x;
  logic signed [DW-1:0] t_x;
  logic signed [DW-1:0] diff;

  always_comb begin
    a_x  = DW'(req.a);
    b_x  = DW'(req.b);
    t_x  = req.use_tol ? $signed({3'b000, tol}) : '0;
    diff = a_x - b_x - t_x;
    gt   = !diff[DW-1] && (diff != '0);
  end

endmodule

[sv/scti_ctrl.sv]
// Sequencer: insert shifting, seek and group scans over the point table.
module scti_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  scti_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output scti_pkg::res_t                res,
  output logic [scti_pkg::IDX_W-1:0]    count,
  output scti_pkg::mem_req_t            mem_req,
  input  logic [scti_pkg::ENT_W-1:0]    mem_rdata,
  output scti_pkg::cmp_req_t            cmp_req,
  input  logic                          cmp_gt
);

  localparam int IW = scti_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EV   = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  typedef enum logic [6:0] {
    PH_INS    = 7'b0000001,
    PH_SEEK_F = 7'b0000010,
    PH_SEEK_B = 7'b0000100,
    PH_HEAD_F = 7'b0001000,
    PH_HEAD_B = 7'b0010000,
    PH_MEM_F  = 7'b0100000,
    PH_MEM_B  = 7'b1000000
  } phase_t;

  state_t                          state_r, state_nxt;
  phase_t                          phase_r, phase_nxt;
  logic [IW-1:0]                   idx_r, idx_nxt;
  logic [IW-1:0]                   anchor_r, anchor_nxt;
  logic [IW-1:0]                   count_r, count_nxt;
  logic                            ready_r, ready_nxt;
  logic signed [scti_pkg::PAR_W-1:0] value_r, value_nxt;
  logic signed [scti_pkg::PAR_W-1:0] base_r, base_nxt;
  logic [scti_pkg::ORI_W-1:0]      new_or_r, new_or_nxt;
  logic [scti_pkg::ORI_W-1:0]      grp_or_r, grp_or_nxt;
  scti_pkg::res_t                  res_r, res_nxt;

  logic signed [scti_pkg::PAR_W-1:0] d_par;
  logic [scti_pkg::ORI_W-1:0]      d_ori;
  logic [IW-1:0]                   idx_dec;
  logic [IW-1:0]                   idx_inc;
  logic                            grp_end;

  assign d_par   = mem_rdata[scti_pkg::ENT_W-1:scti_pkg::ORI_W];
  assign d_ori   = mem_rdata[scti_pkg::ORI_W-1:0];
  assign idx_dec = idx_r - IW'(1);
  assign idx_inc = idx_r + IW'(1);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign res       = res_r;
  assign count     = count_r;

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    anchor_nxt = anchor_r;
    count_nxt  = count_r;
    ready_nxt  = ready_r;
    value_nxt  = value_r;
    base_nxt   = base_r;
    new_or_nxt = new_or_r;
    grp_or_nxt = grp_or_r;
    res_nxt    = res_r;
    mem_req    = '0;
    mem_req.raddr = idx_dec[scti_pkg::AW-1:0];
    cmp_req    = '0;
    grp_end    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt    = '0;
          value_nxt  = in_item.value;
          new_or_nxt = scti_pkg::orient_of(in_item.transition, in_item.face_side);
          state_nxt  = S_OUT;
          if (in_item.action == scti_pkg::ACT_START) begin
            count_nxt = '0;
            ready_nxt = 1'b1;
          end else if (in_item.action <= scti_pkg::ACT_BIDX && !ready_r) begin
            res_nxt.status = scti_pkg::ST_NREADY;
          end else begin
            unique case (in_item.action)
              scti_pkg::ACT_INS: begin
                if (count_r == IW'(scti_pkg::MAX_POINTS)) begin
                  res_nxt.status = scti_pkg::ST_FULL;
                end else begin
                  idx_nxt   = count_r;
                  phase_nxt = PH_INS;
                  state_nxt = S_RD;
                end
              end
              scti_pkg::ACT_AVAL: begin
                idx_nxt   = IW'(1);
                phase_nxt = PH_SEEK_F;
                state_nxt = S_RD;
              end
              scti_pkg::ACT_BVAL: begin
                idx_nxt   = count_r;
                phase_nxt = PH_SEEK_B;
                state_nxt = S_RD;
              end
              scti_pkg::ACT_AIDX: begin
                if (in_item.start_index < count_r) begin
                  // table is sorted, so the seek past start_index is trivial
                  idx_nxt   = (in_item.start_index != '0) ?
                              IW'(in_item.start_index + IW'(1)) : IW'(1);
                  phase_nxt = PH_HEAD_F;
                  state_nxt = S_RD;
                end
              end
              scti_pkg::ACT_BIDX: begin
                if (in_item.start_index > IW'(1)) begin
                  idx_nxt   = (in_item.start_index <= count_r) ?
                              IW'(in_item.start_index - IW'(1)) : count_r;
                  phase_nxt = PH_HEAD_B;
                  state_nxt = S_RD;
                end
              end
              default: ;
            endcase
          end
        end
      end

      S_RD: begin
        state_nxt = S_EV;
        unique case (phase_r)
          PH_INS: begin
            if (idx_r == '0) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = '0;
              mem_req.wdata = {value_r, new_or_r};
              count_nxt     = count_r + IW'(1);
              state_nxt     = S_OUT;
            end
          end
          PH_SEEK_F: begin
            if (idx_r > count_r) begin
              phase_nxt = PH_HEAD_F;
              state_nxt = S_RD;
            end
          end
          PH_SEEK_B: begin
            if (idx_r == '0) begin
              phase_nxt = PH_HEAD_B;
              state_nxt = S_RD;
            end
          end
          PH_HEAD_F, PH_HEAD_B: begin
            if (idx_r == '0 || idx_r > count_r) begin
              state_nxt = S_OUT;
            end
          end
          PH_MEM_F: begin
            if (idx_r > count_r) grp_end = 1'b1;
          end
          PH_MEM_B: begin
            if (idx_r == '0) grp_end = 1'b1;
          end
          default: ;
        endcase
      end

      S_EV: begin
        state_nxt = S_RD;
        unique case (phase_r)
          PH_INS: begin
            cmp_req.a     = d_par;
            cmp_req.b     = value_r;
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_r[scti_pkg::AW-1:0];
            if (cmp_gt) begin
              mem_req.wdata = mem_rdata;
              idx_nxt       = idx_dec;
            end else begin
              mem_req.wdata = {value_r, new_or_r};
              count_nxt     = count_r + IW'(1);
              state_nxt     = S_OUT;
            end
          end
          PH_SEEK_F: begin
            cmp_req = '{a: value_r, b: d_par, use_tol: 1'b1};
            if (cmp_gt) idx_nxt = idx_inc;
            else phase_nxt = PH_HEAD_F;
          end
          PH_SEEK_B: begin
            cmp_req = '{a: d_par, b: value_r, use_tol: 1'b1};
            if (cmp_gt) idx_nxt = idx_dec;
            else phase_nxt = PH_HEAD_B;
          end
          PH_HEAD_F: begin
            anchor_nxt = idx_r;
            grp_or_nxt = d_ori;
            base_nxt   = d_par;
            idx_nxt    = idx_inc;
            phase_nxt  = PH_MEM_F;
          end
          PH_HEAD_B: begin
            anchor_nxt = idx_r;
            grp_or_nxt = d_ori;
            base_nxt   = d_par;
            idx_nxt    = idx_dec;
            phase_nxt  = PH_MEM_B;
          end
          PH_MEM_F, PH_MEM_B: begin
            if (phase_r == PH_MEM_F) begin
              cmp_req = '{a: d_par, b: base_r, use_tol: 1'b1};
            end else begin
              cmp_req = '{a: base_r, b: d_par, use_tol: 1'b1};
            end
            if (!cmp_gt) begin
              if (grp_or_r != scti_pkg::OR_EXT && grp_or_r != d_ori) begin
                grp_or_nxt = scti_pkg::OR_EXT;
              end
              idx_nxt = (phase_r == PH_MEM_F) ? idx_inc : idx_dec;
            end else begin
              grp_end = 1'b1;
            end
          end
          default: ;
        endcase
      end

      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    // group closed: report it if clean, else move on to the next group
    if (grp_end) begin
      if (grp_or_r != scti_pkg::OR_EXT) begin
        res_nxt.found       = 1'b1;
        res_nxt.orientation = grp_or_r;
        if (phase_r == PH_MEM_F) begin
          res_nxt.first_index = anchor_r;
          res_nxt.last_index  = idx_dec;
        end else begin
          res_nxt.first_index = idx_inc;
          res_nxt.last_index  = anchor_r;
        end
        state_nxt = S_OUT;
      end else begin
        phase_nxt = (phase_r == PH_MEM_F) ? PH_HEAD_F : PH_HEAD_B;
        state_nxt = S_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_INS;
      count_r <= '0;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      ready_r <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    anchor_r <= anchor_nxt;
    value_r  <= value_nxt;
    base_r   <= base_nxt;
    new_or_r <= new_or_nxt;
    grp_or_r <= grp_or_nxt;
    res_r    <= res_nxt;
  end

endmodule

[sv/sorted_crossing_table_localizer_unit.sv]
// Sorted crossing table localizer: top level with tolerance register and table RAM.
//
// Channels: in_ch takes one action per transaction (start, insert, or one of
// four searches); out_ch returns exactly one result transaction per action.
// cfg_we/cfg_wdata write the grouping tolerance (unsigned Q15.16, reset value 1 LSB);
// write it only while no action is in flight.
// Sequencing: start, dropped inserts and out-of-range index searches answer
// in the cycle after acceptance. An insert moves each stored point above the
// new value up one slot; a search visits table entries one by one (seek plus
// group scan). Each visit is one RAM read with registered data followed by
// one evaluation step, mostly a pass through the shared compare unit.
// Throughput: one action at a time; in_ch.ready is low from acceptance until
// the result transaction has been taken.
// Reset (rst_n low, synchronous): table empty and not ready, tolerance 1 LSB.
// Stalls: while out_ch.ready is low the result holds steady and no new
// action is accepted.
module sorted_crossing_table_localizer_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  scti_in_if.sink                     in_ch,
  scti_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [scti_pkg::TOL_W-1:0]  cfg_wdata
);

  logic [scti_pkg::TOL_W-1:0] tol_r;
  scti_pkg::in_item_t         in_item;
  scti_pkg::res_t             res;
  logic [scti_pkg::IDX_W-1:0] count;
  scti_pkg::mem_req_t         mem_req;
  logic [scti_pkg::ENT_W-1:0] mem_rdata;
  scti_pkg::cmp_req_t         cmp_req;
  logic                       cmp_gt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= scti_pkg::TOL_W'(1);
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  assign in_item.action      = in_ch.action;
  assign in_item.value       = in_ch.value;
  assign in_item.transition  = in_ch.transition;
  assign in_item.face_side   = in_ch.face_side;
  assign in_item.start_index = in_ch.start_index;

  scti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .res       (res),
    .count     (count),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .cmp_req   (cmp_req),
    .cmp_gt    (cmp_gt)
  );

  scti_ram #(
    .DEPTH (scti_pkg::MAX_POINTS),
    .WIDTH (scti_pkg::ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  scti_cmp u_cmp (
    .req (cmp_req),
    .tol (tol_r),
    .gt  (cmp_gt)
  );

  assign out_ch.status      = res.status;
  assign out_ch.found       = res.found;
  assign out_ch.orientation = res.orientation;
  assign out_ch.first_index = res.first_index;
  assign out_ch.last_index  = res.last_index;
  assign out_ch.point_count = count;

endmodule
